// ----- src/vmb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vmb_pkg;

  localparam int unsigned AddrWidth = 56;
  localparam int unsigned IdxWidth  = 5;

  // Frame constants.
  localparam logic [7:0] BytePreamble = 8'hFE;
  localparam logic [7:0] ByteStart    = 8'h68;
  localparam logic [7:0] ByteMeterTyp = 8'h41;
  localparam logic [7:0] ByteEnd      = 8'h16;
  localparam logic [7:0] TempMin      = 8'h05;
  localparam logic [7:0] TempMax      = 8'h35;

  // Control codes and data identifiers for the two requests.
  localparam logic [7:0] RdCtrl  = 8'h01;
  localparam logic [7:0] RdLen   = 8'h03;
  localparam logic [7:0] RdDi0   = 8'h82;
  localparam logic [7:0] RdDi1   = 8'h1F;
  localparam logic [7:0] SetCtrl = 8'h04;
  localparam logic [7:0] SetLen  = 8'h0B;
  localparam logic [7:0] SetDi0  = 8'h93;
  localparam logic [7:0] SetDi1  = 8'h2F;
  localparam logic [7:0] SetMode = 8'h05;
  localparam logic [7:0] ByteZero = 8'h00;

  // Byte positions within a frame.
  localparam logic [IdxWidth-1:0] IdxStart   = 5'd4;
  localparam logic [IdxWidth-1:0] IdxAddr0   = 5'd6;
  localparam logic [IdxWidth-1:0] IdxAddr6   = 5'd12;
  localparam logic [IdxWidth-1:0] IdxCtrl    = 5'd13;
  localparam logic [IdxWidth-1:0] IdxLen     = 5'd14;
  localparam logic [IdxWidth-1:0] IdxDi0     = 5'd15;
  localparam logic [IdxWidth-1:0] IdxDi1     = 5'd16;
  localparam logic [IdxWidth-1:0] IdxSer     = 5'd17;
  localparam logic [IdxWidth-1:0] IdxTemp    = 5'd18;
  localparam logic [IdxWidth-1:0] IdxMode    = 5'd19;
  localparam logic [IdxWidth-1:0] RdLastIdx  = 5'd19;
  localparam logic [IdxWidth-1:0] SetLastIdx = 5'd27;

  localparam logic KindRead = 1'b0;
  localparam logic KindSet  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] temperature_code;
  } vmb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } vmb_out_t;

  typedef enum logic {
    VMB_IDLE,
    VMB_SEND
  } vmb_state_t;

endpackage

`default_nettype wire

// ----- src/valve_meter_bus_frame_builder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Word
// in_       input      in_valid / in_stall     vmb_in_t  (kind, temperature_code)
// out_      output     out_valid / out_stall   vmb_out_t (frame_byte, last_byte)
// cfg_      input      cfg_wr_en               56-bit valve address
//
// A request is taken while the block is idle, after which the byte sequencer loads
// one frame byte per cycle into the output register unless the output stalls: 20
// bytes for a read, 28 for a set. No new request is taken until the last byte is
// loaded; the single byte counter and the shared checksum adder set this.
// Reset (rst_n low, synchronous) clears the state, the output valid and the
// address register. An output stall holds the current word and pauses the
// sequencer; input is stalled for the whole frame.

module valve_meter_bus_frame_builder
  import vmb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire vmb_in_t              in_data,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      vmb_out_t             out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [AddrWidth-1:0] cfg_wr_data
);

  vmb_state_t            state_r, state_nxt;
  logic [AddrWidth-1:0]  addr_r;
  logic                  kind_r;
  logic [7:0]            temp_r;
  logic [7:0]            temp_clamped;
  logic [IdxWidth-1:0]   idx_r, idx_nxt;
  logic [7:0]            cs_r, cs_nxt;
  logic                  out_valid_r, out_valid_nxt;
  vmb_out_t              out_data_r;
  logic                  in_accept;
  logic                  load;
  logic [IdxWidth-1:0]   last_idx;
  logic [IdxWidth-1:0]   addr_off;
  logic [7:0]            cur_byte;

  assign in_accept = in_valid && !in_stall;
  assign last_idx  = (kind_r == KindSet) ? SetLastIdx : RdLastIdx;
  assign addr_off  = IdxWidth'(idx_r - IdxAddr0);

  // The requested temperature is clamped once, when the request is taken.
  always_comb begin
    if (in_data.temperature_code < TempMin) begin
      temp_clamped = TempMin;
    end else if (in_data.temperature_code > TempMax) begin
      temp_clamped = TempMax;
    end else begin
      temp_clamped = in_data.temperature_code;
    end
  end

  // Frame byte for the current position. The checksum sits one place before
  // the end byte, so both are found relative to the frame length.
  always_comb begin
    cur_byte = ByteZero;
    if (idx_r == last_idx) begin
      cur_byte = ByteEnd;
    end else if (idx_r == IdxWidth'(last_idx - 5'd1)) begin
      cur_byte = cs_r;
    end else begin
      case (idx_r) inside
        [5'd0:5'd3]:          cur_byte = BytePreamble;
        IdxStart:             cur_byte = ByteStart;
        5'd5:                 cur_byte = ByteMeterTyp;
        [IdxAddr0:IdxAddr6]:  cur_byte = addr_r[addr_off[2:0]*8 +: 8];
        IdxCtrl:              cur_byte = (kind_r == KindSet) ? SetCtrl : RdCtrl;
        IdxLen:               cur_byte = (kind_r == KindSet) ? SetLen : RdLen;
        IdxDi0:               cur_byte = (kind_r == KindSet) ? SetDi0 : RdDi0;
        IdxDi1:               cur_byte = (kind_r == KindSet) ? SetDi1 : RdDi1;
        IdxSer:               cur_byte = ByteZero;
        IdxTemp:              cur_byte = temp_r;
        IdxMode:              cur_byte = SetMode;
        default:              cur_byte = ByteZero;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      VMB_IDLE: begin
        if (in_accept) begin
          state_nxt = VMB_SEND;
        end
      end
      VMB_SEND: begin
        if (load && idx_r == last_idx) begin
          state_nxt = VMB_IDLE;
        end
      end
      default: state_nxt = VMB_IDLE;
    endcase
  end

  // Outputs of the sequencer: the output register takes a new byte when it is
  // empty or its word is being taken in this cycle.
  always_comb begin
    in_stall      = (state_r != VMB_IDLE);
    load          = (state_r == VMB_SEND) && (!out_valid_r || !out_stall);
    idx_nxt       = idx_r;
    cs_nxt        = cs_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_accept) begin
      idx_nxt = '0;
      cs_nxt  = '0;
    end else if (load) begin
      idx_nxt       = IdxWidth'(idx_r + 5'd1);
      out_valid_nxt = 1'b1;
      // The checksum runs from the start byte onward; its own position reads
      // the sum before this add, so later adds do no harm.
      if (idx_r >= IdxStart) begin
        cs_nxt = 8'(cs_r + cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= VMB_IDLE;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      idx_r       <= '0;
      cs_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cs_r        <= cs_nxt;
      if (cfg_wr_en) begin
        addr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_data.kind;
      temp_r <= temp_clamped;
    end
    if (load) begin
      out_data_r.frame_byte <= cur_byte;
      out_data_r.last_byte  <= (idx_r == last_idx);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- src/vmb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vmb_checker
  import vmb_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire vmb_out_t             out_data
);

  // Once a request is taken, no other is taken until its frame is built.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a frame is in progress");

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed");

  // Every frame ends in the end byte.
  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_byte) |-> (out_data.frame_byte == ByteEnd))
    else $error("last byte is not the end byte");

  // Inside a frame the bytes follow without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_byte) |=> out_valid)
    else $error("gap inside a frame");

endmodule

bind valve_meter_bus_frame_builder vmb_checker u_vmb_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the valve meter-bus request frame builder.
//
// Every accepted request word is turned into the full expected frame by a
// predictor in this module, one expected output word per frame byte. The
// monitor pops the oldest expected word for every output word that the block
// hands over and compares the byte and the end-of-frame flag separately.
//
// The run is split into phases. The valve address is only rewritten between
// phases, once the request queue has drained and every expected byte has come
// back, so the predictor can use the address that was current at acceptance.
module tb;
  import vmb_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int DrainLimit   = 2000;
  localparam int LongHoldLen  = 300;
  localparam int LongHoldFrom = 60;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  vmb_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  vmb_out_t             out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [AddrWidth-1:0] cfg_wr_data = '0;

  // Requests waiting to be offered, and the frame bytes still owed by the block.
  vmb_in_t  request_queue[$];
  vmb_out_t frame_bytes_due[$];

  // The bench's own copy of the address register, updated with every write.
  logic [AddrWidth-1:0] address_shadow = '0;
  logic                 quiet_tail = 1'b0;

  int requests_sent   = 0;
  int set_requests    = 0;
  int bytes_checked   = 0;
  int failures        = 0;
  int address_writes  = 0;
  int send_gap        = 0;
  int rx_gap          = 0;
  int long_hold_left  = 0;
  bit long_hold_done  = 1'b0;
  int cycle_count     = 0;

  valve_meter_bus_frame_builder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void owe_byte(input logic [7:0] value, input logic is_last);
    vmb_out_t w;
    w.frame_byte = value;
    w.last_byte  = is_last;
    frame_bytes_due.push_back(w);
  endfunction

  // Builds the whole request frame for one request word. The checksum covers
  // everything from the start byte up to the byte in front of it.
  function automatic void append_frame_bytes(input vmb_in_t req,
                                             input logic [AddrWidth-1:0] addr);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] temp;
    body.push_back(ByteStart);
    body.push_back(ByteMeterTyp);
    // Address byte zero goes out first.
    for (int k = 0; k < 7; k++) body.push_back(addr[8*k +: 8]);
    if (req.kind == KindRead) begin
      // A read ignores the temperature entirely.
      body.push_back(RdCtrl);
      body.push_back(RdLen);
      body.push_back(RdDi0);
      body.push_back(RdDi1);
      body.push_back(ByteZero);
    end else begin
      // The requested temperature is clamped into the legal window.
      temp = req.temperature_code;
      if (temp < TempMin) temp = TempMin;
      if (temp > TempMax) temp = TempMax;
      body.push_back(SetCtrl);
      body.push_back(SetLen);
      body.push_back(SetDi0);
      body.push_back(SetDi1);
      body.push_back(ByteZero);
      body.push_back(temp);
      body.push_back(SetMode);
      for (int k = 0; k < 6; k++) body.push_back(ByteZero);
    end
    sum = '0;
    foreach (body[i]) sum += body[i];
    for (int k = 0; k < 4; k++) owe_byte(BytePreamble, 1'b0);
    foreach (body[i]) owe_byte(body[i], 1'b0);
    owe_byte(sum, 1'b0);
    owe_byte(ByteEnd, 1'b1);
  endfunction

  // Sender. An accepted word is handed to the predictor on the spot; the next
  // word goes up only once the current one is gone, so a stalled word holds.
  // After an acceptance the sender sometimes rests for a burst of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        append_frame_bytes(in_data, address_shadow);
        requests_sent++;
        if (in_data.kind == KindSet) set_requests++;
        if (!quiet_tail && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 9);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Checks every accepted output word against the oldest expected
  // one, then decides whether to stall the next cycle. Once enough requests
  // have gone in it holds off for a long stretch, so the block backs up and
  // keeps its input stalled while the sender still has words to offer.
  always @(posedge clk) begin
    vmb_out_t want;
    logic     hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected word: byte %02h last %b", $realtime,
                     out_data.frame_byte, out_data.last_byte);
        end else begin
          want = frame_bytes_due.pop_front();
          bytes_checked++;
          if (out_data.frame_byte !== want.frame_byte ||
              out_data.last_byte !== want.last_byte) begin
            failures++;
            if (failures <= 10)
              $display("%0t: word mismatch: byte %02h last %b, expected byte %02h last %b",
                       $realtime, out_data.frame_byte, out_data.last_byte,
                       want.frame_byte, want.last_byte);
          end
        end
      end
      hold = 1'b0;
      if (!long_hold_done && requests_sent >= LongHoldFrom) begin
        long_hold_left = LongHoldLen;
        long_hold_done = 1'b1;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        hold = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        hold = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 8);
        hold = 1'b1;
      end
      out_stall <= hold;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d bytes still owed.",
               cycle_count, frame_bytes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void queue_request(input logic kind, input logic [7:0] temp);
    vmb_in_t req;
    req.kind             = kind;
    req.temperature_code = temp;
    request_queue.push_back(req);
  endfunction

  // Half the temperatures are spread over the whole byte, the other half sit
  // around the clamp window so both edges get hit often.
  task automatic queue_random_requests(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0)
        queue_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      else
        queue_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 8'h3A)));
    end
  endtask

  // The block counts as idle once nothing is queued, offered or owed for a few
  // cycles in a row; a single look could race with the sender's pop.
  task automatic wait_until_idle(input int limit);
    int calm;
    calm = 0;
    for (int n = 0; n < limit && calm < 4; n++) begin
      @(posedge clk);
      if (request_queue.size() == 0 && !in_valid && frame_bytes_due.size() == 0)
        calm++;
      else
        calm = 0;
    end
  endtask

  task automatic write_address(input logic [AddrWidth-1:0] addr);
    @(posedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_wr_data    <= addr;
    address_shadow <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    address_writes++;
  endtask

  initial begin
    logic [63:0] wide;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The reset address of all zero, before any write.
    queue_request(KindRead, 8'h00);
    queue_request(KindSet, 8'h20);
    queue_request(KindSet, 8'hFF);
    wait_until_idle(CycleLimit);

    // Distinct address bytes show the byte order. Both kinds at the field
    // extremes, and set requests below, at and above each clamp bound.
    write_address(56'h66_55_44_33_22_11_07);
    queue_request(KindRead, 8'hFF);
    queue_request(KindRead, 8'h00);
    queue_request(KindSet, 8'h00);
    queue_request(KindSet, 8'h04);
    queue_request(KindSet, 8'h05);
    queue_request(KindSet, 8'h06);
    queue_request(KindSet, 8'h20);
    queue_request(KindSet, 8'h34);
    queue_request(KindSet, 8'h35);
    queue_request(KindSet, 8'h36);
    queue_request(KindSet, 8'h80);
    queue_request(KindSet, 8'hFF);
    queue_request(KindSet, 8'h55);
    queue_request(KindSet, 8'hAA);
    wait_until_idle(CycleLimit);

    // Random content under a handful of addresses, the extremes among them.
    // The long receiver hold-off lands in the first of these phases.
    wide = {$urandom, $urandom};
    write_address(wide[AddrWidth-1:0]);
    queue_random_requests(80);
    wait_until_idle(CycleLimit);

    write_address({AddrWidth{1'b1}});
    queue_random_requests(80);
    wait_until_idle(CycleLimit);

    write_address('0);
    queue_random_requests(70);
    wait_until_idle(CycleLimit);

    write_address(56'hAA_55_AA_55_AA_55_AA);
    queue_random_requests(70);
    wait_until_idle(CycleLimit);

    // Last stretch runs back to back with no idling on either side.
    wide = {$urandom, $urandom};
    write_address(wide[AddrWidth-1:0]);
    quiet_tail <= 1'b1;
    queue_random_requests(100);

    wait_until_idle(DrainLimit + CycleLimit / 2);
    repeat (40) @(posedge clk);
    if (frame_bytes_due.size() != 0) begin
      failures++;
      $display("%0d expected bytes never arrived.", frame_bytes_due.size());
    end

    $display("Sent %0d requests (%0d set, %0d read) under %0d address settings.",
             requests_sent, set_requests, requests_sent - set_requests, address_writes + 1);
    $display("Checked %0d frame bytes with %0d failures, long receiver hold-off %s.",
             bytes_checked, failures, long_hold_done ? "done" : "missed");
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/vmb_pkg.sv
src/valve_meter_bus_frame_builder.sv
src/vmb_checker.sv
bench/tb.sv
